// ===== hdl/rcde_pkg.sv =====
package rcde_pkg;

  localparam int CANVAS_ROWS_DEF = 32;
  localparam int CANVAS_COLS_DEF = 64;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;
  localparam int CRD_W      = 9;
  localparam int LEN_W      = 8;
  localparam int ROWIDX_W   = 5;
  localparam int SQ_W       = 18;

  localparam logic [2:0] OP_RECT   = 3'd0;
  localparam logic [2:0] OP_LINE   = 3'd1;
  localparam logic [2:0] OP_TRI    = 3'd2;
  localparam logic [2:0] OP_CIRC   = 3'd3;
  localparam logic [2:0] OP_CLR    = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_CLRALL = 3'd6;

  typedef enum logic [2:0] {
    K_RECT, K_LINE, K_TRI, K_CIRC, K_CLR, K_READ, K_CLRALL, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [CRD_W-1:0]   fx;
    logic signed [CRD_W-1:0]   fy;
    logic signed [CRD_W-1:0]   sx;
    logic signed [CRD_W-1:0]   sy;
    logic [LEN_W-1:0]          w;
    logic [LEN_W-1:0]          h;
    logic [LEN_W-1:0]          r;
    logic [ROWIDX_W-1:0]       row;
    logic [SQ_W-1:0]           lo_sq;
    logic [SQ_W-1:0]           hi_sq;
  } cmd_t;

endpackage

// ===== hdl/rcde_front.sv =====
module rcde_front import rcde_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 q_vld,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  cmd_t       dec;
  logic [2:0] opcode;
  logic [8:0] lo, hi;
  logic       push;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign opcode  = in_tdata[2:0];
  assign dec.fx  = $signed(in_tdata[11:3]);
  assign dec.fy  = $signed(in_tdata[20:12]);
  assign dec.sx  = $signed(in_tdata[29:21]);
  assign dec.sy  = $signed(in_tdata[38:30]);
  assign dec.w   = in_tdata[46:39];
  assign dec.h   = in_tdata[54:47];
  assign dec.r   = in_tdata[62:55];
  assign dec.row = in_tdata[67:63];

  assign lo        = {in_tdata[62:55], 1'b0} - 9'd1;
  assign hi        = {in_tdata[62:55], 1'b0} + 9'd1;
  assign dec.lo_sq = lo * lo;
  assign dec.hi_sq = hi * hi;

  always_comb begin
    case (opcode)
      OP_RECT:   dec.kind = K_RECT;
      OP_LINE:   dec.kind = K_LINE;
      OP_TRI:    dec.kind = K_TRI;
      OP_CIRC:   dec.kind = K_CIRC;
      OP_CLR:    dec.kind = K_CLR;
      OP_READ:   dec.kind = K_READ;
      OP_CLRALL: dec.kind = K_CLRALL;
      default:   dec.kind = K_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_vld     = (cnt_r != 2'd0);
  assign q_cmd     = q_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

// ===== hdl/rcde_back.sv =====
module rcde_back import rcde_pkg::*; #(
  parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
  parameter int CANVAS_COLS = CANVAS_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int ROW_AW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int COL_AW = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(CANVAS_ROWS - 1);
  localparam logic [COL_AW-1:0] LAST_COL = COL_AW'(CANVAS_COLS - 1);
  localparam logic signed [9:0] ROWS_S = 10'(CANVAS_ROWS);
  localparam logic signed [9:0] COLS_S = 10'(CANVAS_COLS);
  localparam logic [6:0] ROWS_U = 7'(CANVAS_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ROW_RD, S_ROW_WR, S_LN_RD, S_LN_WR, S_RD_RD, S_RD_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic [CANVAS_ROWS-1:0] row_vld_r, row_vld_nxt;

  cmd_t cmd_r, cmd_nxt;
  logic [ROW_AW-1:0] row_r, row_nxt;
  logic [COL_AW-1:0] col_r, col_nxt;
  logic [16:0] dysq_r, dysq_nxt;
  logic signed [9:0] lx_r, lx_nxt, ly_r, ly_nxt, lex_r, lex_nxt, ley_r, ley_nxt;
  logic [9:0] ldx_r, ldx_nxt, ldy_r, ldy_nxt;
  logic lsx_r, lsx_nxt, lsy_r, lsy_nxt;
  logic signed [12:0] err_r, err_nxt;
  logic [OUT_DATA_W-1:0] out_bits_r, out_bits_nxt;
  logic out_rd_r, out_rd_nxt;

  logic [16:0] sq_r [CANVAS_COLS];
  logic        sq_we;
  logic [16:0] sq_val;

  // canvas store
  logic [CANVAS_COLS-1:0] mem [CANVAS_ROWS];
  logic [CANVAS_COLS-1:0] rd_data_r, row_cur, wr_data;
  logic                   rd_hit_r, mem_we;
  logic [ROW_AW-1:0]      rd_addr, wr_addr;

  // row sweep terms
  logic signed [10:0] ri, fx11, fy11, sx11, sy11, w11, h11;
  logic signed [10:0] rect_x2, rect_y2, tt, hm, tri_by, dyv, dxv;
  logic signed [21:0] dy_prod, dx_prod;
  logic rect_row, rect_edge, tri_diag, tri_base, clr_row;
  logic [CANVAS_COLS-1:0] m_rect, m_tri, m_circ, m_clr, sel_mask, lmask;

  // line terms
  logic signed [9:0] ax, ay, bx, by, ddx, ddy;
  logic signed [13:0] e2;
  logic c1, c2, l_in, l_done;

  assign ri   = $signed(11'(row_r));
  assign fx11 = 11'(cmd_r.fx);
  assign fy11 = 11'(cmd_r.fy);
  assign sx11 = 11'(cmd_r.sx);
  assign sy11 = 11'(cmd_r.sy);
  assign w11  = $signed({3'b000, cmd_r.w});
  assign h11  = $signed({3'b000, cmd_r.h});

  assign rect_x2   = fx11 + w11 - 11'sd1;
  assign rect_y2   = fy11 + h11 - 11'sd1;
  assign rect_row  = (cmd_r.w != '0) && (cmd_r.h != '0) && (ri >= fy11) && (ri <= rect_y2);
  assign rect_edge = (ri == fy11) || (ri == rect_y2);

  assign tt       = ri - fy11;
  assign hm       = (cmd_r.h == '0) ? 11'sd1 : (h11 - 11'sd1);
  assign tri_by   = fy11 + h11 - 11'sd1;
  assign tri_diag = (tt >= 11'sd0) && (tt < h11);
  assign tri_base = (ri == tri_by);

  assign clr_row = (ri >= fy11) && (ri <= sy11);

  assign dyv     = ri - fy11;
  assign dy_prod = dyv * dyv;
  assign dxv     = $signed(11'(col_r)) - fx11;
  assign dx_prod = dxv * dxv;
  assign sq_val  = 17'(dx_prod);

  for (genvar j = 0; j < CANVAS_COLS; j++) begin : g_col
    localparam logic signed [10:0] CJ = 11'(j);
    logic [17:0] s;
    logic [19:0] d4;
    assign s  = 18'(sq_r[j]) + 18'(dysq_r);
    assign d4 = {s, 2'b00};
    assign m_rect[j] = rect_row && (CJ >= fx11) && (CJ <= rect_x2) &&
                       (rect_edge || (CJ == fx11) || (CJ == rect_x2));
    assign m_tri[j]  = (tri_diag && ((CJ == fx11 - tt) || (CJ == fx11 + tt))) ||
                       (tri_base && (CJ >= fx11 - hm) && (CJ <= fx11 + hm));
    assign m_circ[j] = ((cmd_r.r == '0) || (d4 >= 20'(cmd_r.lo_sq))) &&
                       (d4 <= 20'(cmd_r.hi_sq));
    assign m_clr[j]  = clr_row && (CJ >= fx11) && (CJ <= sx11);
  end

  always_comb begin
    case (cmd_r.kind)
      K_RECT:  sel_mask = m_rect;
      K_TRI:   sel_mask = m_tri;
      K_CIRC:  sel_mask = m_circ;
      default: sel_mask = '0;
    endcase
  end

  assign row_cur = rd_hit_r ? rd_data_r : '0;

  // bresenham setup and step
  assign ax  = 10'(q_cmd.fx);
  assign ay  = 10'(q_cmd.fy);
  assign bx  = 10'(q_cmd.sx);
  assign by  = 10'(q_cmd.sy);
  assign ddx = (bx > ax) ? (bx - ax) : (ax - bx);
  assign ddy = (by > ay) ? (by - ay) : (ay - by);

  assign e2     = {err_r[12], err_r} <<< 1;
  assign c1     = e2 > -$signed({4'b0000, ldy_r});
  assign c2     = e2 < $signed({4'b0000, ldx_r});
  assign l_in   = (lx_r >= 10'sd0) && (lx_r < COLS_S) && (ly_r >= 10'sd0) && (ly_r < ROWS_S);
  assign l_done = (lx_r == lex_r) && (ly_r == ley_r);
  assign lmask  = CANVAS_COLS'(1) << lx_r[COL_AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    row_vld_nxt  = row_vld_r;
    cmd_nxt      = cmd_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    dysq_nxt     = dysq_r;
    lx_nxt       = lx_r;
    ly_nxt       = ly_r;
    lex_nxt      = lex_r;
    ley_nxt      = ley_r;
    ldx_nxt      = ldx_r;
    ldy_nxt      = ldy_r;
    lsx_nxt      = lsx_r;
    lsy_nxt      = lsy_r;
    err_nxt      = err_r;
    out_bits_nxt = out_bits_r;
    out_rd_nxt   = out_rd_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    sq_we        = 1'b0;
    rd_addr      = row_r;
    wr_addr      = row_r;
    wr_data      = (cmd_r.kind == K_CLR) ? (row_cur & ~m_clr) : (row_cur | sel_mask);
    case (state_r)
      S_IDLE: begin
        if (q_vld && !out_vld_r) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_cmd;
          row_nxt      = '0;
          col_nxt      = '0;
          out_bits_nxt = '0;
          out_rd_nxt   = 1'b0;
          lx_nxt       = ax;
          ly_nxt       = ay;
          lex_nxt      = bx;
          ley_nxt      = by;
          ldx_nxt      = ddx;
          ldy_nxt      = ddy;
          lsx_nxt      = !(ax < bx);
          lsy_nxt      = !(ay < by);
          err_nxt      = 13'(ddx) - 13'(ddy);
          case (q_cmd.kind)
            K_RECT, K_TRI, K_CLR: state_nxt = S_ROW_RD;
            K_CIRC:  state_nxt = S_SQ;
            K_LINE:  state_nxt = S_LN_RD;
            K_READ:  state_nxt = S_RD_RD;
            K_CLRALL: begin
              row_vld_nxt = '0;
              out_vld_nxt = 1'b1;
            end
            default: out_vld_nxt = 1'b1;
          endcase
        end
      end
      S_SQ: begin
        sq_we = 1'b1;
        if (col_r == LAST_COL) begin
          state_nxt = S_ROW_RD;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_ROW_RD: begin
        dysq_nxt  = 17'(dy_prod);
        state_nxt = S_ROW_WR;
      end
      S_ROW_WR: begin
        mem_we = 1'b1;
        row_vld_nxt[row_r] = 1'b1;
        if (row_r == LAST_ROW) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_ROW_RD;
        end
      end
      S_LN_RD: begin
        rd_addr   = ly_r[ROW_AW-1:0];
        state_nxt = S_LN_WR;
      end
      S_LN_WR: begin
        wr_addr = ly_r[ROW_AW-1:0];
        wr_data = row_cur | lmask;
        if (l_in) begin
          mem_we = 1'b1;
          row_vld_nxt[ly_r[ROW_AW-1:0]] = 1'b1;
        end
        if (l_done) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          err_nxt = err_r - (c1 ? $signed({3'b000, ldy_r}) : 13'sd0)
                          + (c2 ? $signed({3'b000, ldx_r}) : 13'sd0);
          if (c1) begin
            lx_nxt = lsx_r ? (lx_r - 10'sd1) : (lx_r + 10'sd1);
          end
          if (c2) begin
            ly_nxt = lsy_r ? (ly_r - 10'sd1) : (ly_r + 10'sd1);
          end
          state_nxt = S_LN_RD;
        end
      end
      S_RD_RD: begin
        rd_addr   = ROW_AW'(cmd_r.row);
        state_nxt = S_RD_WR;
      end
      S_RD_WR: begin
        out_rd_nxt   = 1'b1;
        out_bits_nxt = ({2'b00, cmd_r.row} < ROWS_U) ? OUT_DATA_W'(row_cur) : '0;
        out_vld_nxt  = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      row_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      row_vld_r <= row_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    dysq_r     <= dysq_nxt;
    lx_r       <= lx_nxt;
    ly_r       <= ly_nxt;
    lex_r      <= lex_nxt;
    ley_r      <= ley_nxt;
    ldx_r      <= ldx_nxt;
    ldy_r      <= ldy_nxt;
    lsx_r      <= lsx_nxt;
    lsy_r      <= lsy_nxt;
    err_r      <= err_nxt;
    out_bits_r <= out_bits_nxt;
    out_rd_r   <= out_rd_nxt;
    if (sq_we) begin
      sq_r[col_r] <= sq_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_hit_r  <= row_vld_r[rd_addr];
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_bits_r;
  assign out_tuser  = out_rd_r;

endmodule

// ===== hdl/raster_canvas_draw_engine.sv =====
// channel   dir  ports                         payload (low bit first)
// in        in   in_tvalid in_tready in_tdata  opcode first_x first_y second_x second_y
//                                              width height radius row_index, 4 zero bits
// out       out  out_tvalid out_tready         tdata: row_bits; tuser: is_read
//
// rectangle, triangle and clear area sweep every canvas row, each read then written
// circle first fills its column squares, column by column, before the sweep
// line reads then writes a row per plotted point; clear all drops the row valid bits
// rst_n clears the row valid bits, so the canvas reads as blank with no clearing pass
// a two-entry command queue takes transfers while the engine or out stalls, until full
module raster_canvas_draw_engine import rcde_pkg::*; #(
  parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
  parameter int CANVAS_COLS = CANVAS_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode, first_x, first_y, second_x, second_y, width, height, radius, row_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row_bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  // is_read
  output logic                  out_tuser
);

  logic q_vld, q_pop;
  cmd_t q_cmd;

  rcde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_vld     (q_vld),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  rcde_back #(
    .CANVAS_ROWS (CANVAS_ROWS),
    .CANVAS_COLS (CANVAS_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/raster_canvas_draw_engine_chk.sv =====
module raster_canvas_draw_engine_chk import rcde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    fail_count,
  output int                    pending
);

  localparam int NROWS = 32;
  localparam int NCOLS = 64;

  logic [63:0] canvas [NROWS];
  logic [64:0] want_q [$];

  function automatic void set_px(int px, int py, bit on);
    if (px < 0 || px >= NCOLS || py < 0 || py >= NROWS) return;
    canvas[py][px] = on;
  endfunction

  function automatic void trace_line(int ax, int ay, int bx, int by);
    int dx, dy, stx, sty, err, e2;
    dx = bx > ax ? bx - ax : ax - bx;
    dy = by > ay ? by - ay : ay - by;
    stx = ax < bx ? 1 : -1;
    sty = ay < by ? 1 : -1;
    err = dx - dy;
    forever begin
      set_px(ax, ay, 1);
      if (ax == bx && ay == by) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        ax += stx;
      end
      if (e2 < dx) begin
        err += dx;
        ay += sty;
      end
    end
  endfunction

  function automatic logic [64:0] apply_cmd(logic [IN_DATA_W-1:0] d);
    logic [2:0] op;
    int fx, fy, sx, sy, w, h, r, lo, hi, d4;
    logic [4:0] row;
    logic [64:0] res;
    op = d[2:0];
    fx = $signed(d[11:3]);
    fy = $signed(d[20:12]);
    sx = $signed(d[29:21]);
    sy = $signed(d[38:30]);
    w = d[46:39];
    h = d[54:47];
    r = d[62:55];
    row = d[67:63];
    res = '0;
    case (op)
      OP_RECT: begin
        for (int i = fy; i < fy + h && i < NROWS; i++)
          for (int j = fx; j < fx + w && j < NCOLS; j++)
            if (i == fy || i == fy + h - 1 || j == fx || j == fx + w - 1) set_px(j, i, 1);
      end
      OP_LINE: trace_line(fx, fy, sx, sy);
      OP_TRI: begin
        for (int i = 0; i < h; i++) begin
          set_px(fx - i, fy + i, 1);
          set_px(fx + i, fy + i, 1);
        end
        trace_line(fx - h + 1, fy + h - 1, fx + h - 1, fy + h - 1);
      end
      OP_CIRC: begin
        lo = 2 * r - 1;
        hi = 2 * r + 1;
        for (int y = 0; y < NROWS; y++)
          for (int x = 0; x < NCOLS; x++) begin
            d4 = 4 * ((x - fx) * (x - fx) + (y - fy) * (y - fy));
            if ((r == 0 || d4 >= lo * lo) && d4 <= hi * hi) set_px(x, y, 1);
          end
      end
      OP_CLR: begin
        for (int i = fy; i <= sy && i < NROWS; i++)
          for (int j = fx; j <= sx && j < NCOLS; j++) set_px(j, i, 0);
      end
      OP_READ: res = {1'b1, canvas[row]};
      OP_CLRALL: for (int i = 0; i < NROWS; i++) canvas[i] = '0;
      default: ;
    endcase
    return res;
  endfunction

  logic [64:0] exp_v;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NROWS; i++) canvas[i] <= '0;
      want_q.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) want_q.push_back(apply_cmd(in_tdata));
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h %b", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = want_q.pop_front();
          if (out_tdata !== exp_v[63:0] || out_tuser !== exp_v[64]) begin
            if (fail_count < 10)
              $display("mismatch: exp row_bits %h is_read %b, got %h %b",
                       exp_v[63:0], exp_v[64], out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = want_q.size();

endmodule

// ===== tb/raster_canvas_draw_engine_tb.sv =====
module raster_canvas_draw_engine_tb import rcde_pkg::*;;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  int                    fail_count;
  int                    pending;
  int                    send_idle = 0;
  int                    recv_idle = 0;
  int                    cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  raster_canvas_draw_engine u_top (.*);

  raster_canvas_draw_engine_chk u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [IN_DATA_W-1:0] pack_cmd(logic [2:0] op, int fx, int fy,
      int sx, int sy, int w, int h, int r, int row);
    logic [8:0] a, b, c, d;
    a = 9'(fx); b = 9'(fy); c = 9'(sx); d = 9'(sy);
    return {4'b0, 5'(row), 8'(r), 8'(h), 8'(w), d, c, b, a, op};
  endfunction

  task automatic send_cmd(logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_read(int row);
    send_cmd(pack_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, row));
  endtask

  function automatic int rc();
    return ($urandom_range(9) == 0) ? $signed(9'($urandom)) : $urandom_range(70) - 4;
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_cmd();
    logic [2:0] op;
    int k;
    k = $urandom_range(99);
    if (k < 30) op = OP_READ;
    else if (k < 32) op = OP_CLRALL;
    else if (k < 33) op = 3'd7;
    else op = 3'($urandom_range(4));
    return pack_cmd(op, rc(), rc(), rc(), rc(),
                    $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(40),
                    $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(24),
                    $urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(30),
                    $urandom_range(31));
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_idle = 36;
    recv_idle = 81;
    send_cmd(pack_cmd(OP_RECT, 2, 3, 0, 0, 10, 6, 0, 0));
    send_cmd(pack_cmd(OP_RECT, -5, -5, 0, 0, 255, 255, 0, 0));
    send_cmd(pack_cmd(OP_RECT, 1, 1, 0, 0, 0, 5, 0, 0));
    send_read(3);
    send_cmd(pack_cmd(OP_LINE, -256, -256, 255, 255, 0, 0, 0, 0));
    send_cmd(pack_cmd(OP_LINE, 63, 0, 0, 31, 0, 0, 0, 0));
    send_read(8);
    send_cmd(pack_cmd(OP_TRI, 30, 10, 0, 0, 0, 0, 0, 0));
    send_cmd(pack_cmd(OP_TRI, 20, 2, 0, 0, 0, 8, 0, 0));
    send_read(9);
    send_cmd(pack_cmd(OP_CIRC, 32, 16, 0, 0, 0, 0, 0, 0));
    send_cmd(pack_cmd(OP_CIRC, 32, 16, 0, 0, 0, 0, 10, 0));
    send_cmd(pack_cmd(OP_CIRC, -100, 200, 0, 0, 0, 0, 255, 0));
    send_read(16);
    send_cmd(pack_cmd(OP_CLR, 10, 10, 5, 20, 0, 0, 0, 0));
    send_cmd(pack_cmd(OP_CLR, -256, -256, 40, 20, 0, 0, 0, 0));
    send_read(31);
    send_read(0);
    send_cmd(pack_cmd(3'd7, -1, -1, -1, -1, 255, 255, 255, 31));
    send_cmd(pack_cmd(OP_CLRALL, 0, 0, 0, 0, 0, 0, 0, 0));
    send_read(6);
    for (int n = 0; n < 1400; n++) begin
      if (n == 460) begin
        send_idle = 81;
        recv_idle = 36;
      end
      if (n == 930) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (n == 700) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_cmd(rand_cmd());
    end
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
